/* hw/rtl/kvt_pkg.sv */
// Shared types and constants for the key/value table.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int DefTableDepth = 16;
  localparam int DefKeyWidth   = 32;
  localparam int DefValueWidth = 32;
  localparam int OpWidth       = 2;
  localparam int StatusWidth   = 2;
  localparam int CountOutWidth = 5;

  typedef enum logic [OpWidth-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_RESP
  } back_state_t;

endpackage

/* hw/rtl/kvt_front.sv */
// Front end: accepts request transactions, decodes them and queues them for the back end.
`timescale 1ns / 1ps

module kvt_front #(
  parameter int KEY_WIDTH   = kvt_pkg::DefKeyWidth,
  parameter int VALUE_WIDTH = kvt_pkg::DefValueWidth
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // operation, key, value (from bit 0), zero padded to bytes
  input  logic [((kvt_pkg::OpWidth+KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output kvt_pkg::op_t             cmd_op,
  output logic [KEY_WIDTH-1:0]     cmd_key,
  output logic [VALUE_WIDTH-1:0]   cmd_value
);
  import kvt_pkg::*;

  localparam int KeyLsb   = OpWidth;
  localparam int ValueLsb = OpWidth + KEY_WIDTH;

  op_t                    q_op    [2];
  logic [KEY_WIDTH-1:0]   q_key   [2];
  logic [VALUE_WIDTH-1:0] q_value [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             fill;
  logic                   push;
  logic                   pop;
  op_t                    in_op;

  assign in_op     = op_t'(s_tdata[OpWidth-1:0]);
  assign s_tready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_op    = q_op[rd_ptr];
  assign cmd_key   = q_key[rd_ptr];
  assign cmd_value = q_value[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]    <= in_op;
      q_key[wr_ptr]   <= s_tdata[KeyLsb +: KEY_WIDTH];
      q_value[wr_ptr] <= s_tdata[ValueLsb +: VALUE_WIDTH];
    end
  end

endmodule

/* hw/rtl/kvt_back.sv */
// Back end: parallel key match, slot update, value store and result register.
`timescale 1ns / 1ps

module kvt_back #(
  parameter int TABLE_DEPTH = kvt_pkg::DefTableDepth,
  parameter int KEY_WIDTH   = kvt_pkg::DefKeyWidth,
  parameter int VALUE_WIDTH = kvt_pkg::DefValueWidth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  kvt_pkg::op_t           cmd_op,
  input  logic [KEY_WIDTH-1:0]   cmd_key,
  input  logic [VALUE_WIDTH-1:0] cmd_value,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status, found_value, entry_count (from bit 0), zero padded to bytes
  output logic [((kvt_pkg::StatusWidth+VALUE_WIDTH+kvt_pkg::CountOutWidth+7)/8)*8-1:0] m_tdata
);
  import kvt_pkg::*;

  localparam int IdxW    = $clog2(TABLE_DEPTH);
  localparam int CntW    = $clog2(TABLE_DEPTH + 1);
  localparam int OutBits = StatusWidth + VALUE_WIDTH + CountOutWidth;
  localparam int OutW    = ((OutBits + 7) / 8) * 8;

  back_state_t state, state_next;

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [KEY_WIDTH-1:0]   slot_key  [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [CntW-1:0]        occupied;
  logic [CntW-1:0]        count_next;

  op_t                    op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [TABLE_DEPTH-1:0] match_r;
  logic [TABLE_DEPTH-1:0] match_now;

  logic [IdxW-1:0]        hit_idx;
  logic [IdxW-1:0]        free_idx;
  logic                   hit_any;
  logic                   any_free;
  logic                   do_insert;
  logic                   do_remove;
  status_t                exec_status;

  status_t                res_status;
  logic [CountOutWidth-1:0] res_count;
  logic                   res_found;

  status_t                out_status;
  logic [VALUE_WIDTH-1:0] out_found;
  logic [CountOutWidth-1:0] out_count;

  logic                   out_free;
  logic                   load_cmd;
  logic                   load_out;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_now[i] = slot_valid[i] && (slot_key[i] == cmd_key);
    end
  end

  // keys are unique, so at most one match bit is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_r[i]) hit_idx = hit_idx | IdxW'(i);
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) free_idx = IdxW'(i);
    end
  end

  assign hit_any  = |match_r;
  assign any_free = ~&slot_valid;

  always_comb begin
    exec_status = ST_OK;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    count_next  = occupied;
    unique case (op_r)
      OP_INSERT: begin
        if (hit_any) exec_status = ST_DUP;
        else if (!any_free) exec_status = ST_FULL;
        else begin
          do_insert  = 1'b1;
          count_next = occupied + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (hit_any) begin
          do_remove  = 1'b1;
          count_next = occupied - CntW'(1);
        end else begin
          exec_status = ST_MISSING;
        end
      end
      OP_LOOKUP: begin
        if (!hit_any) exec_status = ST_MISSING;
      end
      OP_NOP: begin
        exec_status = ST_OK;
      end
      default: begin
        exec_status = ST_OK;
      end
    endcase
  end

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) state_next = B_EXEC;
      end
      B_EXEC: begin
        state_next = B_RESP;
      end
      B_RESP: begin
        if (out_free) begin
          load_out   = 1'b1;
          cmd_ready  = 1'b1;
          state_next = cmd_valid ? B_EXEC : B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  assign load_cmd = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      occupied   <= '0;
    end else if (state == B_EXEC) begin
      occupied <= count_next;
      if (do_insert) slot_valid[free_idx] <= 1'b1;
      if (do_remove) slot_valid[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      op_r    <= cmd_op;
      key_r   <= cmd_key;
      value_r <= cmd_value;
      match_r <= match_now;
    end
    if (state == B_EXEC) begin
      res_status <= exec_status;
      res_count  <= CountOutWidth'(count_next);
      res_found  <= (op_r == OP_LOOKUP) && hit_any;
      if (do_insert) slot_key[free_idx] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EXEC && do_insert) value_mem[free_idx] <= value_r;
    if (state == B_EXEC) rd_data <= value_mem[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_found  <= res_found ? rd_data : '0;
      out_count  <= res_count;
    end
  end

  assign m_tdata = OutW'({out_count, out_found, out_status});

endmodule

/* hw/rtl/key_value_table_unit.sv */
// Top level of the key/value table: request front end, queue and table back end.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry requests: operation (insert, remove,
//   lookup, or no-op for code three), key and value. m_tvalid/m_tready/m_tdata
//   carry one result per request: status, found value and the entry count
//   after the operation.
//   A request waits in a two-entry queue in the front end. The back end takes
//   it, matches the key against all slots in parallel as it takes it,
//   updates the slot and value store in the next cycle, and registers the result.
//   The back end takes a new request only once it has passed the previous
//   result to the output register, so its match-then-update sequence on the
//   slot table serves one request at a time.
//   Reset clears all slot valid bits, the entry count, the queue and the
//   result valid flag; the table is ready in the first cycle after reset.
//   When the receiver stalls, the result holds, the back end waits, and the
//   queue still takes up to two more requests before s_tready drops.
`timescale 1ns / 1ps

module key_value_table_unit #(
  parameter int TABLE_DEPTH = kvt_pkg::DefTableDepth,
  parameter int KEY_WIDTH   = kvt_pkg::DefKeyWidth,
  parameter int VALUE_WIDTH = kvt_pkg::DefValueWidth
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // operation, key, value (from bit 0), zero padded to bytes
  input  logic [((kvt_pkg::OpWidth+KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status, found_value, entry_count (from bit 0), zero padded to bytes
  output logic [((kvt_pkg::StatusWidth+VALUE_WIDTH+kvt_pkg::CountOutWidth+7)/8)*8-1:0] m_tdata
);
  import kvt_pkg::*;

  logic                   cmd_valid;
  logic                   cmd_ready;
  op_t                    cmd_op;
  logic [KEY_WIDTH-1:0]   cmd_key;
  logic [VALUE_WIDTH-1:0] cmd_value;

  kvt_front #(
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_op   (cmd_op),
    .cmd_key  (cmd_key),
    .cmd_value(cmd_value)
  );

  kvt_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_op   (cmd_op),
    .cmd_key  (cmd_key),
    .cmd_value(cmd_value),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for key_value_table_unit: shadow table prediction under random flow control.
`timescale 1ns / 1ps

module tb_top;
  import kvt_pkg::*;

  localparam int Depth = DefTableDepth;
  localparam int KeyW = DefKeyWidth;
  localparam int ValW = DefValueWidth;
  localparam int ReqW = ((OpWidth + KeyW + ValW + 7) / 8) * 8;
  localparam int RspW = ((StatusWidth + ValW + CountOutWidth + 7) / 8) * 8;
  localparam int PoolSize = 24;
  localparam int RandPerPhase = 400;

  typedef struct packed {
    status_t status;
    logic [ValW-1:0] found;
    logic [CountOutWidth-1:0] count;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // operation, key, value (from bit 0), zero padded
  logic [ReqW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // status, found_value, entry_count (from bit 0), zero padded
  logic [RspW-1:0] m_tdata;

  logic [ReqW-1:0] pending_requests[$];
  reply_t expected_replies[$];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int error_count = 0;

  logic shadow_valid[Depth];
  logic [KeyW-1:0] shadow_key[Depth];
  logic [ValW-1:0] shadow_value[Depth];
  int shadow_count = 0;
  logic [KeyW-1:0] key_pool[PoolSize];

  key_value_table_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int shadow_find(logic [KeyW-1:0] k);
    for (int i = 0; i < Depth; i++)
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    return Depth;
  endfunction

  function automatic reply_t shadow_apply(logic [ReqW-1:0] word);
    op_t op;
    logic [KeyW-1:0] k;
    logic [ValW-1:0] v;
    int hit;
    int free_idx;
    reply_t r;
    op = op_t'(word[OpWidth-1:0]);
    k = word[OpWidth +: KeyW];
    v = word[OpWidth+KeyW +: ValW];
    hit = shadow_find(k);
    free_idx = Depth;
    r.status = ST_OK;
    r.found = '0;
    case (op)
      OP_INSERT: begin
        if (hit < Depth) begin
          r.status = ST_DUP;
        end else begin
          for (int i = Depth - 1; i >= 0; i--)
            if (!shadow_valid[i]) free_idx = i;
          if (free_idx == Depth) begin
            r.status = ST_FULL;
          end else begin
            shadow_valid[free_idx] = 1'b1;
            shadow_key[free_idx] = k;
            shadow_value[free_idx] = v;
            shadow_count++;
          end
        end
      end
      OP_REMOVE: begin
        if (hit < Depth) begin
          shadow_valid[hit] = 1'b0;
          if (shadow_count > 0) shadow_count--;
        end else begin
          r.status = ST_MISSING;
        end
      end
      OP_LOOKUP: begin
        if (hit < Depth) r.found = shadow_value[hit];
        else r.status = ST_MISSING;
      end
      default: ;
    endcase
    r.count = CountOutWidth'(shadow_count);
    return r;
  endfunction

  function automatic void enqueue_request(op_t op, logic [KeyW-1:0] k, logic [ValW-1:0] v);
    pending_requests.push_back(ReqW'({v, k, op}));
  endfunction

  // Pool keys are mostly reused so inserts, removes and lookups hit each other.
  task automatic add_random_traffic(int n);
    int pick;
    op_t op;
    logic [KeyW-1:0] k;
    repeat (n) begin
      pick = $urandom_range(99);
      k = key_pool[$urandom_range(PoolSize - 1)];
      if (pick < 45) op = OP_INSERT;
      else if (pick < 70) op = OP_REMOVE;
      else if (pick < 95) op = OP_LOOKUP;
      else op = OP_NOP;
      if (op != OP_INSERT && $urandom_range(99) < 15) k = $urandom;
      enqueue_request(op, k, $urandom);
    end
  endtask

  // Only called when idle, so the shadow table is exact: keys still stored stay in the pool.
  task automatic refresh_pool;
    for (int j = 2; j < PoolSize; j++)
      if (shadow_find(key_pool[j]) == Depth && $urandom_range(1) == 1) key_pool[j] = $urandom;
  endtask

  task automatic drain;
    while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_replies.push_back(shadow_apply(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_requests.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    reply_t want;
    logic [StatusWidth-1:0] got_status;
    logic [ValW-1:0] got_found;
    logic [CountOutWidth-1:0] got_count;
    if (!rst && m_tvalid && m_tready) begin
      got_status = m_tdata[StatusWidth-1:0];
      got_found = m_tdata[StatusWidth +: ValW];
      got_count = m_tdata[StatusWidth+ValW +: CountOutWidth];
      if (expected_replies.size() == 0) begin
        $error("unexpected result transaction, tdata %h", m_tdata);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (got_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_status);
          error_count++;
        end
        if (got_found !== want.found) begin
          $error("found_value: expected %h, got %h", want.found, got_found);
          error_count++;
        end
        if (got_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, got_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < Depth; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, extremes, duplicates, no-op, fill, full, head removal
    enqueue_request(OP_LOOKUP, key_pool[2], '0);
    enqueue_request(OP_REMOVE, '1, '0);
    enqueue_request(OP_INSERT, '0, '0);
    enqueue_request(OP_INSERT, '1, '1);
    enqueue_request(OP_INSERT, '0, 32'h1234_5678);
    enqueue_request(OP_LOOKUP, '0, '1);
    enqueue_request(OP_LOOKUP, '1, '0);
    enqueue_request(OP_NOP, '1, '1);
    for (int i = 2; i < Depth; i++) enqueue_request(OP_INSERT, key_pool[i], $urandom);
    enqueue_request(OP_INSERT, key_pool[Depth], $urandom);
    enqueue_request(OP_INSERT, '1, '0);
    enqueue_request(OP_REMOVE, '0, '1);
    enqueue_request(OP_LOOKUP, '0, '0);
    enqueue_request(OP_INSERT, key_pool[Depth], '1);
    enqueue_request(OP_LOOKUP, key_pool[Depth], '0);
    add_random_traffic(RandPerPhase);
    drain();

    sender_idle_pct = 79;
    refresh_pool();
    add_random_traffic(RandPerPhase);
    drain();

    sender_idle_pct = 0;
    receiver_stall_pct = 79;
    refresh_pool();
    add_random_traffic(RandPerPhase);
    drain();

    sender_idle_pct = 12;
    receiver_stall_pct = 12;
    refresh_pool();
    add_random_traffic(RandPerPhase);
    drain();

    repeat (20) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d expected results never arrived", expected_replies.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[key_value_table_unit] OK");
    end else begin
      $display("[key_value_table_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[key_value_table_unit] ERROR");
    $finish;
  end

endmodule
